// File: design/cdk_pkg.sv
// Types, constants and saturating fixed-point helpers for the clock offset/drift filter.
package cdk_pkg;

   localparam int CNT_W = 7;

   localparam logic [63:0] U_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] Q16_LIM = 64'h0000_8000_0000_0000;
   localparam logic [63:0] DRIFT_ONE = 64'h0000_4000_0000_0000;

   localparam logic [1:0] MODE_UPDATE    = 2'd0;
   localparam logic [1:0] MODE_TO_REMOTE = 2'd1;
   localparam logic [1:0] MODE_TO_LOCAL  = 2'd2;
   localparam logic [1:0] MODE_CLEAR     = 2'd3;

   localparam logic CSR_PROCESS_VARIANCE = 1'b0;
   localparam logic CSR_FORGET_FACTOR    = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   typedef enum logic [22:0] {
      SP_MV   = 23'h000001,
      SP_CHK  = 23'h000002,
      SP_SD1  = 23'h000004,
      SP_SD2  = 23'h000008,
      SP_SDC  = 23'h000010,
      SP_PRED = 23'h000020,
      SP_TMP  = 23'h000040,
      SP_PA   = 23'h000080,
      SP_PB   = 23'h000100,
      SP_PC   = 23'h000200,
      SP_RES  = 23'h000400,
      SP_F11  = 23'h000800,
      SP_F01  = 23'h001000,
      SP_F00  = 23'h002000,
      SP_GS   = 23'h004000,
      SP_K0   = 23'h008000,
      SP_K1   = 23'h010000,
      SP_UOFF = 23'h020000,
      SP_UDR  = 23'h040000,
      SP_UP11 = 23'h080000,
      SP_UP01 = 23'h100000,
      SP_UP00 = 23'h200000,
      SP_Q1   = 23'h400000
   } step_type;

   typedef enum logic [2:0] {
      DV_IDLE  = 3'b001,
      DV_RUN   = 3'b010,
      DV_ROUND = 3'b100
   } div_state_type;

   typedef enum logic [2:0] {
      SH0, SH16, SH28, SH30, SH46
   } sh_type;

   function automatic logic [63:0] mag(input logic [63:0] x);
      return x[63] ? (64'd0 - x) : x;
   endfunction

   function automatic logic [63:0] sat_signed(input logic neg, input logic [63:0] m);
      if (neg) begin
         return m[63] ? S_MIN : (64'd0 - m);
      end
      return m[63] ? S_MAX : m;
   endfunction

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? S_MIN : S_MAX;
      end
      return s;
   endfunction

   // bit 64 flags overflow
   function automatic logic [64:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] d;
      d = a - b;
      if (a[63] != b[63] && d[63] != a[63]) begin
         return {1'b1, (a[63] ? S_MIN : S_MAX)};
      end
      return {1'b0, d};
   endfunction

   function automatic logic [63:0] uadd(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? U_MAX : s[63:0];
   endfunction

   function automatic logic [63:0] uadd_sm(input logic [63:0] a, input logic neg,
                                           input logic [63:0] m);
      if (neg) begin
         return (a >= m) ? (a - m) : 64'd0;
      end
      return uadd(a, m);
   endfunction

   function automatic logic [47:0] sat48(input logic [63:0] x);
      if ($signed(x) >= $signed(Q16_LIM)) begin
         return 48'h7FFF_FFFF_FFFF;
      end
      if ($signed(x) < -$signed(Q16_LIM)) begin
         return 48'h8000_0000_0000;
      end
      return x[47:0];
   endfunction

   function automatic logic [63:0] to_q16(input logic [63:0] us);
      if ($signed(us) >= $signed(Q16_LIM)) begin
         return S_MAX;
      end
      if ($signed(us) < -$signed(Q16_LIM)) begin
         return S_MIN;
      end
      return {us[47:0], 16'd0};
   endfunction

   function automatic logic [63:0] round_q16(input logic [63:0] x);
      logic [63:0] r;
      r = (mag(x) + 64'd32768) >> 16;
      return x[63] ? (64'd0 - r) : r;
   endfunction

   function automatic logic [63:0] umul_post(input logic [127:0] p, input sh_type sh);
      logic [128:0] s;
      logic [128:0] q;
      s = {1'b0, p};
      case (sh)
         SH16: begin
            s = {1'b0, p} + (129'd1 << 15);
            q = s >> 16;
         end
         SH28: begin
            s = {1'b0, p} + (129'd1 << 27);
            q = s >> 28;
         end
         SH30: begin
            s = {1'b0, p} + (129'd1 << 29);
            q = s >> 30;
         end
         SH46: begin
            s = {1'b0, p} + (129'd1 << 45);
            q = s >> 46;
         end
         default: begin
            q = s;
         end
      endcase
      return (|q[128:64]) ? U_MAX : q[63:0];
   endfunction

endpackage

// File: design/cdk_mul.sv
// Bit-serial 64x64 unsigned multiplier, one multiplier bit per cycle.
module cdk_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] prod
);
   import cdk_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] hi_ff, hi_in;
   logic [63:0] lo_ff, lo_in;

   always_comb begin
      logic [64:0] sum;
      sum = {1'b0, hi_ff} + (b_ff[0] ? {1'b0, a_ff} : 65'd0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      a_in = a_ff;
      b_in = b_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         a_in = a;
         b_in = b;
         hi_in = '0;
         lo_in = '0;
      end else if (busy_ff) begin
         hi_in = sum[64:1];
         lo_in = {sum[0], lo_ff[63:1]};
         b_in = {1'b0, b_ff[63:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff <= a_in;
      b_ff <= b_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

endmodule

// File: design/cdk_div.sv
// Bit-serial restoring divider, 128 by 64 bits, rounded and saturated quotient.
module cdk_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] num,
   input  logic [63:0]  den,
   output logic         done,
   output logic [63:0]  quo
);
   import cdk_pkg::*;

   div_state_type state_ff, state_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] lo_ff, lo_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] q_ff, q_in;

   always_comb begin
      logic [64:0] sh;
      logic        take;
      sh = {rem_ff, lo_ff[63]};
      take = (sh >= {1'b0, den_ff});
      state_in = state_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      lo_in = lo_ff;
      den_in = den_ff;
      q_in = q_ff;
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               den_in = den;
               rem_in = num[127:64];
               lo_in = num[63:0];
               cnt_in = '0;
               q_in = '0;
               if (num[127:64] >= den) begin
                  q_in = U_MAX;
                  done_in = 1'b1;
               end else begin
                  state_in = DV_RUN;
               end
            end
         end
         DV_RUN: begin
            rem_in = take ? (sh[63:0] - den_ff) : sh[63:0];
            lo_in = {lo_ff[62:0], 1'b0};
            q_in = {q_ff[62:0], take};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = DV_ROUND;
            end
         end
         DV_ROUND: begin
            if (rem_ff >= den_ff - rem_ff && q_ff != U_MAX) begin
               q_in = q_ff + 64'd1;
            end
            done_in = 1'b1;
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      lo_ff <= lo_in;
      den_ff <= den_in;
      q_ff <= q_in;
   end

   assign done = done_ff;
   assign quo = q_ff;

endmodule

// File: design/clock_offset_drift_kalman_top.sv
// Two-state clock offset/drift filter with a shared bit-serial multiplier and divider.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  mode, time_stamp, measured_offset, error_bound
//   rsp      out        rsp_valid/rsp_ready  time_out, offset_now, drift_now, bad_interval
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// The shared units work one bit per cycle.
// Full update: 11 to 14 multiplies and 0 or 2 divides.
// Reset clears the filter at once. A word waiting on rsp does not block req; a
// finished word holds in the last state until rsp frees.
module clock_offset_drift_kalman_top #(
   parameter int WARMUP_UPDATES = 100
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [63:0] req_time_stamp,
   input  logic signed [63:0] req_measured_offset,
   input  logic [31:0]        req_error_bound,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_time_out,
   output logic signed [63:0] rsp_offset_now,
   output logic signed [47:0] rsp_drift_now,
   output logic               rsp_bad_interval,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [31:0]        csr_write_data
);
   import cdk_pkg::*;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   logic [31:0]      pv_ff, pv_in;
   logic [31:0]      fv_ff, fv_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      lut_ff, lut_in;
   logic [63:0]      off_ff, off_in;
   logic [47:0]      drift_ff, drift_in;
   logic [63:0]      p00_ff, p00_in;
   logic [63:0]      p01_ff, p01_in;
   logic [63:0]      p11_ff, p11_in;

   logic [63:0] t_ff, t_in;
   logic [63:0] mq_ff, mq_in;
   logic [31:0] me_ff, me_in;
   logic [63:0] mv_ff, mv_in;
   logic [63:0] dt_ff, dt_in;
   logic [63:0] pred_ff, pred_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] tmp_ff, tmp_in;
   logic [63:0] p00n_ff, p00n_in;
   logic [63:0] p01n_ff, p01n_in;
   logic [63:0] p11n_ff, p11n_in;
   logic [63:0] s_ff, s_in;
   logic [63:0] k0_ff, k0_in;
   logic [63:0] k1_ff, k1_in;
   logic [63:0] tout_ff, tout_in;
   logic        bad_ff, bad_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_time_ff, rsp_time_in;
   logic [63:0] rsp_off_ff, rsp_off_in;
   logic [47:0] rsp_drift_ff, rsp_drift_in;
   logic        rsp_bad_ff, rsp_bad_in;

   logic         mul_start, mul_done;
   logic [63:0]  mul_a, mul_b;
   logic [127:0] mul_prod;
   logic         div_start, div_done;
   logic [127:0] div_num;
   logic [63:0]  div_den;
   logic [63:0]  div_quo;

   cdk_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   cdk_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      logic [64:0] sr;
      logic [63:0] drift64;
      logic [63:0] den64;
      logic [63:0] thr;
      logic [63:0] v;
      logic [63:0] w;
      logic [63:0] y;
      logic [63:0] q;

      drift64 = {{16{drift_ff[47]}}, drift_ff};
      den64 = DRIFT_ONE + drift64;
      thr = ({32'd0, me_ff} << 15) + ({32'd0, me_ff} << 14);
      sr = '0;
      v = '0;
      w = '0;
      y = '0;
      q = '0;

      state_in = state_ff;
      step_in = step_ff;
      pv_in = pv_ff;
      fv_in = fv_ff;
      cnt_in = cnt_ff;
      lut_in = lut_ff;
      off_in = off_ff;
      drift_in = drift_ff;
      p00_in = p00_ff;
      p01_in = p01_ff;
      p11_in = p11_ff;
      t_in = t_ff;
      mq_in = mq_ff;
      me_in = me_ff;
      mv_in = mv_ff;
      dt_in = dt_ff;
      pred_in = pred_ff;
      res_in = res_ff;
      tmp_in = tmp_ff;
      p00n_in = p00n_ff;
      p01n_in = p01n_ff;
      p11n_in = p11n_ff;
      s_in = s_ff;
      k0_in = k0_ff;
      k1_in = k1_ff;
      tout_in = tout_ff;
      bad_in = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_time_in = rsp_time_ff;
      rsp_off_in = rsp_off_ff;
      rsp_drift_in = rsp_drift_ff;
      rsp_bad_in = rsp_bad_ff;
      mul_start = 1'b0;
      mul_a = '0;
      mul_b = '0;
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_PROCESS_VARIANCE: pv_in = csr_write_data;
            CSR_FORGET_FACTOR:    fv_in = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               t_in = req_time_stamp;
               mq_in = to_q16(req_measured_offset);
               me_in = req_error_bound;
               bad_in = 1'b0;
               tout_in = '0;
               state_in = ST_RUN;
               sr = sat_sub(req_time_stamp, lut_ff);
               case (req_mode)
                  MODE_UPDATE: begin
                     step_in = SP_MV;
                  end
                  MODE_TO_REMOTE: begin
                     dt_in = sr[63:0];
                     step_in = SP_Q1;
                  end
                  MODE_TO_LOCAL: begin
                     sr = sat_sub(to_q16(sr[63:0]), off_ff);
                     y = sr[63:0];
                     res_in = y;
                     step_in = SP_Q1;
                     if (den64 == 64'd0) begin
                        q = (y == 64'd0) ? 64'd0 : (y[63] ? S_MIN : S_MAX);
                        tout_in = sat_add(lut_ff, q);
                        state_in = ST_FIN;
                     end else begin
                        div_start = 1'b1;
                        div_num = {64'd0, mag(y)} << 30;
                        div_den = mag(den64);
                        state_in = ST_WAIT;
                     end
                  end
                  default: begin
                     cnt_in = '0;
                     lut_in = '0;
                     off_in = '0;
                     drift_in = '0;
                     p00_in = U_MAX;
                     p01_in = '0;
                     p11_in = '0;
                     state_in = ST_FIN;
                  end
               endcase
            end
         end

         ST_RUN: begin
            state_in = ST_WAIT;
            case (step_ff)
               SP_MV: begin
                  mul_start = 1'b1;
                  mul_a = {32'd0, me_ff};
                  mul_b = {32'd0, me_ff};
               end
               SP_CHK: begin
                  sr = sat_sub(t_ff, lut_ff);
                  state_in = ST_RUN;
                  if (cnt_ff == '0) begin
                     off_in = mq_ff;
                     p00_in = mv_ff;
                     drift_in = '0;
                     lut_in = t_ff;
                     cnt_in = CNT_W'(1);
                     state_in = ST_FIN;
                  end else if (sr[64] || $signed(sr[63:0]) <= 0) begin
                     bad_in = 1'b1;
                     state_in = ST_FIN;
                  end else begin
                     lut_in = t_ff;
                     dt_in = sr[63:0];
                     step_in = (cnt_ff == CNT_W'(1)) ? SP_SD1 : SP_PRED;
                  end
               end
               SP_SD1: begin
                  sr = sat_sub(mq_ff, off_ff);
                  y = sr[63:0];
                  res_in = y;
                  div_start = 1'b1;
                  div_num = {64'd0, mag(y)} << 30;
                  div_den = dt_ff;
               end
               SP_SD2: begin
                  v = uadd(p00_ff, mv_ff);
                  if (v == U_MAX) begin
                     p11_in = U_MAX;
                     step_in = SP_SDC;
                     state_in = ST_RUN;
                  end else begin
                     div_start = 1'b1;
                     div_num = {64'd0, v};
                     div_den = dt_ff;
                  end
               end
               SP_SDC: begin
                  off_in = mq_ff;
                  p00_in = mv_ff;
                  cnt_in = CNT_W'(2);
                  state_in = ST_FIN;
               end
               SP_PRED, SP_Q1: begin
                  mul_start = 1'b1;
                  mul_a = mag(drift64);
                  mul_b = mag(dt_ff);
               end
               SP_TMP: begin
                  mul_start = 1'b1;
                  mul_a = p11_ff;
                  mul_b = dt_ff;
               end
               SP_PA: begin
                  mul_start = 1'b1;
                  mul_a = mag(p01_ff);
                  mul_b = dt_ff;
               end
               SP_PB: begin
                  mul_start = 1'b1;
                  mul_a = tmp_ff;
                  mul_b = dt_ff;
               end
               SP_PC: begin
                  mul_start = 1'b1;
                  mul_a = {24'd0, pv_ff, 8'd0};
                  mul_b = dt_ff;
               end
               SP_RES: begin
                  sr = sat_sub(mq_ff, pred_ff);
                  res_in = sr[63:0];
                  state_in = ST_RUN;
                  step_in = SP_GS;
                  if (cnt_ff < CNT_W'(WARMUP_UPDATES)) begin
                     cnt_in = cnt_ff + CNT_W'(1);
                  end else if ($signed(sr[63:0]) > $signed(thr)) begin
                     step_in = SP_F11;
                  end
               end
               SP_F11: begin
                  mul_start = 1'b1;
                  mul_a = p11n_ff;
                  mul_b = {32'd0, fv_ff};
               end
               SP_F01: begin
                  mul_start = 1'b1;
                  mul_a = mag(p01n_ff);
                  mul_b = {32'd0, fv_ff};
               end
               SP_F00: begin
                  mul_start = 1'b1;
                  mul_a = p00n_ff;
                  mul_b = {32'd0, fv_ff};
               end
               SP_GS: begin
                  v = uadd(p00n_ff, mv_ff);
                  s_in = v;
                  state_in = ST_RUN;
                  if (v == 64'd0) begin
                     k0_in = '0;
                     k1_in = '0;
                     step_in = SP_UOFF;
                  end else begin
                     step_in = SP_K0;
                  end
               end
               SP_K0: begin
                  div_start = 1'b1;
                  div_num = {64'd0, p00n_ff} << 46;
                  div_den = s_ff;
               end
               SP_K1: begin
                  div_start = 1'b1;
                  div_num = {64'd0, mag(p01n_ff)} << 46;
                  div_den = s_ff;
               end
               SP_UOFF: begin
                  mul_start = 1'b1;
                  mul_a = k0_ff;
                  mul_b = mag(res_ff);
               end
               SP_UDR: begin
                  mul_start = 1'b1;
                  mul_a = mag(k1_ff);
                  mul_b = mag(res_ff);
               end
               SP_UP11: begin
                  mul_start = 1'b1;
                  mul_a = mag(k1_ff);
                  mul_b = mag(p01n_ff);
               end
               SP_UP01: begin
                  mul_start = 1'b1;
                  mul_a = mag(k1_ff);
                  mul_b = p00n_ff;
               end
               SP_UP00: begin
                  mul_start = 1'b1;
                  mul_a = k0_ff;
                  mul_b = p00n_ff;
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end

         ST_WAIT: begin
            if (mul_done || div_done) begin
               state_in = ST_RUN;
               case (step_ff)
                  SP_MV: begin
                     v = mul_prod[63:0];
                     mv_in = (v > (U_MAX >> 22)) ? U_MAX : (v << 22);
                     step_in = SP_CHK;
                  end
                  SP_SD1: begin
                     drift_in = sat48(sat_signed(res_ff[63], div_quo));
                     step_in = SP_SD2;
                  end
                  SP_SD2: begin
                     p11_in = div_quo;
                     step_in = SP_SDC;
                  end
                  SP_PRED: begin
                     v = sat_signed(drift_ff[47], umul_post(mul_prod, SH30));
                     pred_in = sat_add(off_ff, v);
                     step_in = SP_TMP;
                  end
                  SP_TMP: begin
                     v = umul_post(mul_prod, SH0);
                     tmp_in = v;
                     p01n_in = sat_add(p01_ff, sat_signed(1'b0, v));
                     p11n_in = p11_ff;
                     step_in = SP_PA;
                  end
                  SP_PA: begin
                     v = sat_signed(p01_ff[63], umul_post(mul_prod, SH0));
                     w = sat_add(v, v);
                     p00n_in = uadd_sm(p00_ff, w[63], mag(w));
                     step_in = SP_PB;
                  end
                  SP_PB: begin
                     p00n_in = uadd(p00n_ff, umul_post(mul_prod, SH0));
                     step_in = SP_PC;
                  end
                  SP_PC: begin
                     p00n_in = uadd(p00n_ff, umul_post(mul_prod, SH0));
                     step_in = SP_RES;
                  end
                  SP_F11: begin
                     p11n_in = umul_post(mul_prod, SH28);
                     step_in = SP_F01;
                  end
                  SP_F01: begin
                     p01n_in = sat_signed(p01n_ff[63], umul_post(mul_prod, SH28));
                     step_in = SP_F00;
                  end
                  SP_F00: begin
                     p00n_in = umul_post(mul_prod, SH28);
                     step_in = SP_GS;
                  end
                  SP_K0: begin
                     k0_in = sat_signed(1'b0, div_quo);
                     step_in = SP_K1;
                  end
                  SP_K1: begin
                     k1_in = sat_signed(p01n_ff[63], div_quo);
                     step_in = SP_UOFF;
                  end
                  SP_UOFF: begin
                     v = sat_signed(res_ff[63], umul_post(mul_prod, SH46));
                     off_in = sat_add(pred_ff, v);
                     step_in = SP_UDR;
                  end
                  SP_UDR: begin
                     v = sat_signed(k1_ff[63] ^ res_ff[63], umul_post(mul_prod, SH16));
                     drift_in = sat48(sat_add(drift64, v));
                     step_in = SP_UP11;
                  end
                  SP_UP11: begin
                     p11_in = uadd_sm(p11n_ff, k1_ff[63] == p01n_ff[63],
                                      umul_post(mul_prod, SH46));
                     step_in = SP_UP01;
                  end
                  SP_UP01: begin
                     v = sat_signed(!k1_ff[63], umul_post(mul_prod, SH46));
                     p01_in = sat_add(p01n_ff, v);
                     step_in = SP_UP00;
                  end
                  SP_UP00: begin
                     p00_in = uadd_sm(p00n_ff, 1'b1, umul_post(mul_prod, SH46));
                     state_in = ST_FIN;
                  end
                  SP_Q1: begin
                     if (div_done) begin
                        q = sat_signed(res_ff[63] ^ den64[63], div_quo);
                        tout_in = sat_add(lut_ff, q);
                     end else begin
                        v = sat_signed(drift_ff[47] ^ dt_ff[63], umul_post(mul_prod, SH30));
                        w = sat_add(off_ff, v);
                        tout_in = sat_add(t_ff, round_q16(w));
                     end
                     state_in = ST_FIN;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end

         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_time_in = tout_ff;
               rsp_off_in = round_q16(off_ff);
               rsp_drift_in = drift_ff;
               rsp_bad_in = bad_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= SP_MV;
         pv_ff <= 32'h0001_0000;
         fv_ff <= 32'h1000_0000;
         cnt_ff <= '0;
         lut_ff <= '0;
         off_ff <= '0;
         drift_ff <= '0;
         p00_ff <= U_MAX;
         p01_ff <= '0;
         p11_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         pv_ff <= pv_in;
         fv_ff <= fv_in;
         cnt_ff <= cnt_in;
         lut_ff <= lut_in;
         off_ff <= off_in;
         drift_ff <= drift_in;
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p11_ff <= p11_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff <= t_in;
      mq_ff <= mq_in;
      me_ff <= me_in;
      mv_ff <= mv_in;
      dt_ff <= dt_in;
      pred_ff <= pred_in;
      res_ff <= res_in;
      tmp_ff <= tmp_in;
      p00n_ff <= p00n_in;
      p01n_ff <= p01n_in;
      p11n_ff <= p11n_in;
      s_ff <= s_in;
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      tout_ff <= tout_in;
      bad_ff <= bad_in;
      rsp_time_ff <= rsp_time_in;
      rsp_off_ff <= rsp_off_in;
      rsp_drift_ff <= rsp_drift_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_time_out = rsp_time_ff;
   assign rsp_offset_now = rsp_off_ff;
   assign rsp_drift_now = rsp_drift_ff;
   assign rsp_bad_interval = rsp_bad_ff;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the clock offset/drift Kalman filter top level.
`timescale 1ns / 100ps

module testbench;
   import cdk_pkg::*;

   localparam int LIMIT_CYCLES = 8000000;
   localparam int SETTLE_CYCLES = 1500;
   localparam int PHASE_ITEMS = 185;
   localparam int WARMUP = 100;

   typedef struct packed {
      logic [63:0] time_out;
      logic [63:0] offset_now;
      logic [47:0] drift_now;
      logic        bad;
   } rsp_word_type;

   typedef struct {
      logic [1:0]   mode;
      logic [63:0]  ts;
      logic [63:0]  meas;
      logic [31:0]  me;
      bit           typed;
      rsp_word_type word;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = MODE_CLEAR;
   logic signed [63:0] req_time_stamp = '0;
   logic signed [63:0] req_measured_offset = '0;
   logic [31:0]        req_error_bound = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [63:0] rsp_time_out;
   logic signed [63:0] rsp_offset_now;
   logic signed [47:0] rsp_drift_now;
   logic               rsp_bad_interval;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = CSR_PROCESS_VARIANCE;
   logic [31:0]        csr_write_data = '0;

   rsp_word_type expected_words[$];
   bit        failed = 1'b0;
   int        words_sent = 0;
   int        cycle_count = 0;

   // filter copy
   int          f_count;
   logic [63:0] f_last, f_off, f_drift, f_p00, f_p01, f_p11;
   logic [63:0] cfg_pv, cfg_ff;

   clock_offset_drift_kalman_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_time_stamp(req_time_stamp), .req_measured_offset(req_measured_offset),
      .req_error_bound(req_error_bound),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_time_out(rsp_time_out),
      .rsp_offset_now(rsp_offset_now), .rsp_drift_now(rsp_drift_now),
      .rsp_bad_interval(rsp_bad_interval),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #2 clock = ~clock;

   function automatic logic [63:0] abs64(input logic [63:0] x);
      return x[63] ? -x : x;
   endfunction

   function automatic logic [63:0] sign_clip(input logic neg, input logic [63:0] m);
      if (neg) return (m >= S_MIN) ? S_MIN : -m;
      return m[63] ? S_MAX : m;
   endfunction

   function automatic logic [63:0] add_s(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S_MIN : S_MAX;
      return s;
   endfunction

   function automatic logic [63:0] sub_s(input logic [63:0] a, input logic [63:0] b,
                                         output bit ov);
      logic [64:0] d;
      d = {a[63], a} - {b[63], b};
      ov = (d[64] != d[63]);
      if (ov) return d[64] ? S_MIN : S_MAX;
      return d[63:0];
   endfunction

   function automatic logic [63:0] add_u(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? U_MAX : s[63:0];
   endfunction

   function automatic logic [63:0] add_u_sm(input logic [63:0] a, input logic neg,
                                            input logic [63:0] m);
      if (neg) return (a >= m) ? a - m : 64'd0;
      return add_u(a, m);
   endfunction

   function automatic logic [63:0] clip48(input logic [63:0] x);
      if ($signed(x) >= $signed(Q16_LIM)) return 64'h0000_7FFF_FFFF_FFFF;
      if ($signed(x) < -$signed(Q16_LIM)) return 64'hFFFF_8000_0000_0000;
      return x;
   endfunction

   function automatic logic [63:0] us_to_q16(input logic [63:0] us);
      if ($signed(us) >= $signed(Q16_LIM)) return S_MAX;
      if ($signed(us) < -$signed(Q16_LIM)) return S_MIN;
      return us << 16;
   endfunction

   function automatic logic [63:0] q16_to_us(input logic [63:0] x);
      logic [63:0] r;
      r = (abs64(x) + 64'd32768) >> 16;
      return x[63] ? -r : r;
   endfunction

   function automatic logic [63:0] mul_rnd(input logic [63:0] a, input logic [63:0] b,
                                           input int sh);
      logic [127:0] p;
      logic [128:0] s;
      p = {64'd0, a} * {64'd0, b};
      if (sh == 0) return (|p[127:64]) ? U_MAX : p[63:0];
      s = ({1'b0, p} + (129'd1 << (sh - 1))) >> sh;
      return (|s[128:64]) ? U_MAX : s[63:0];
   endfunction

   function automatic logic [63:0] mul_rnd_s(input logic [63:0] a, input logic [63:0] b,
                                             input int sh);
      return sign_clip(a[63] != b[63], mul_rnd(abs64(a), abs64(b), sh));
   endfunction

   function automatic logic [63:0] div_rnd(input logic [63:0] hi, input logic [63:0] lo,
                                           input logic [63:0] den);
      logic [127:0] num, q, r;
      logic [63:0] qq, rem;
      if (hi >= den) return U_MAX;
      num = {hi, lo};
      q = num / {64'd0, den};
      r = num % {64'd0, den};
      qq = q[63:0];
      rem = r[63:0];
      if (rem >= den - rem && qq != U_MAX) qq = qq + 64'd1;
      return qq;
   endfunction

   function automatic logic [63:0] div_scaled(input logic [63:0] m, input int sh,
                                              input logic [63:0] den);
      logic [127:0] num;
      num = {64'd0, m} << sh;
      return div_rnd(num[127:64], num[63:0], den);
   endfunction

   task automatic clear_filter();
      f_count = 0;
      f_last = '0;
      f_off = '0;
      f_drift = '0;
      f_p00 = U_MAX;
      f_p01 = '0;
      f_p11 = '0;
   endtask

   task automatic kalman_update(input logic [63:0] t, input logic [63:0] meas,
                                input logic [31:0] me, output bit bad);
      logic [63:0] m2, mv, mq, dt, pred, res, p01n, k0, k1, a, diff, thr;
      logic [63:0] p00n, p11n, tmp, s, mk1;
      bit ov, k1neg;
      bad = 1'b0;
      m2 = {32'd0, me} * {32'd0, me};
      mv = (m2 > (U_MAX >> 22)) ? U_MAX : m2 << 22;
      mq = us_to_q16(meas);
      if (f_count == 0) begin
         f_off = mq;
         f_p00 = mv;
         f_drift = '0;
         f_last = t;
         f_count = 1;
         return;
      end
      dt = sub_s(t, f_last, ov);
      if (ov || $signed(dt) <= 0) begin
         bad = 1'b1;
         return;
      end
      f_last = t;
      if (f_count == 1) begin
         diff = sub_s(mq, f_off, ov);
         f_drift = clip48(sign_clip(diff[63], div_scaled(abs64(diff), 30, dt)));
         f_off = mq;
         s = add_u(f_p00, mv);
         f_p11 = (s == U_MAX) ? U_MAX : div_rnd(64'd0, s, dt);
         f_p00 = mv;
         f_count = 2;
         return;
      end
      pred = add_s(f_off, mul_rnd_s(f_drift, dt, 30));
      p11n = f_p11;
      tmp = mul_rnd(f_p11, dt, 0);
      p01n = add_s(f_p01, sign_clip(1'b0, tmp));
      a = mul_rnd_s(f_p01, dt, 0);
      a = add_s(a, a);
      p00n = add_u_sm(f_p00, a[63], abs64(a));
      p00n = add_u(p00n, mul_rnd(tmp, dt, 0));
      p00n = add_u(p00n, mul_rnd(cfg_pv << 8, dt, 0));
      res = sub_s(mq, pred, ov);
      thr = {32'd0, me} * 64'd49152;
      if (f_count < WARMUP) begin
         f_count++;
      end else if ($signed(res) > $signed(thr)) begin
         p11n = mul_rnd(p11n, cfg_ff, 28);
         p01n = sign_clip(p01n[63], mul_rnd(abs64(p01n), cfg_ff, 28));
         p00n = mul_rnd(p00n, cfg_ff, 28);
      end
      s = add_u(p00n, mv);
      if (s == 0) begin
         k0 = '0;
         k1 = '0;
      end else begin
         k0 = sign_clip(1'b0, div_scaled(p00n, 46, s));
         k1 = sign_clip(p01n[63], div_scaled(abs64(p01n), 46, s));
      end
      k1neg = k1[63];
      mk1 = abs64(k1);
      f_off = add_s(pred, mul_rnd_s(k0, res, 46));
      f_drift = clip48(add_s(f_drift, mul_rnd_s(k1, res, 16)));
      f_p11 = add_u_sm(p11n, k1neg == p01n[63], mul_rnd(mk1, abs64(p01n), 46));
      f_p01 = add_s(p01n, sign_clip(!k1neg, mul_rnd(mk1, p00n, 46)));
      f_p00 = add_u_sm(p00n, 1'b1, mul_rnd(k0, p00n, 46));
   endtask

   task automatic kalman_step(input logic [1:0] mode, input logic [63:0] t,
                              input logic [63:0] meas, input logic [31:0] me,
                              output rsp_word_type w);
      logic [63:0] tout, d, off, y, den, q;
      bit bad, ov;
      tout = '0;
      bad = 1'b0;
      case (mode)
         MODE_UPDATE: kalman_update(t, meas, me, bad);
         MODE_TO_REMOTE: begin
            d = sub_s(t, f_last, ov);
            off = add_s(f_off, mul_rnd_s(f_drift, d, 30));
            tout = add_s(t, q16_to_us(off));
         end
         MODE_TO_LOCAL: begin
            y = sub_s(us_to_q16(sub_s(t, f_last, ov)), f_off, ov);
            den = DRIFT_ONE + f_drift;
            if (den == 0) q = (y == 0) ? 64'd0 : (y[63] ? S_MIN : S_MAX);
            else q = sign_clip(y[63] != den[63], div_scaled(abs64(y), 30, abs64(den)));
            tout = add_s(f_last, q);
         end
         default: clear_filter();
      endcase
      w.time_out = tout;
      w.offset_now = q16_to_us(f_off);
      w.drift_now = f_drift[47:0];
      w.bad = bad;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 300);
   endfunction

   task automatic send_word(input stim_row_type row);
      int gap;
      rsp_word_type w;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= row.mode;
      req_time_stamp <= row.ts;
      req_measured_offset <= row.meas;
      req_error_bound <= row.me;
      do @(posedge clock); while (!req_ready);
      kalman_step(row.mode, row.ts, row.meas, row.me, w);
      expected_words.push_back(row.typed ? row.word : w);
      words_sent++;
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_PROCESS_VARIANCE) cfg_pv = {32'd0, data};
      else cfg_ff = {32'd0, data};
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic stim_row_type mk(input logic [1:0] mode, input logic [63:0] ts,
                                       input logic [63:0] meas, input logic [31:0] me);
      stim_row_type r;
      r.mode = mode;
      r.ts = ts;
      r.meas = meas;
      r.me = me;
      r.typed = 1'b0;
      r.word = '0;
      return r;
   endfunction

   function automatic stim_row_type mk_typed(input logic [1:0] mode, input logic [63:0] ts,
                                             input logic [63:0] meas, input logic [31:0] me,
                                             input logic [63:0] tout, input logic [63:0] off,
                                             input logic bad);
      stim_row_type r;
      r = mk(mode, ts, meas, me);
      r.typed = 1'b1;
      r.word = '{tout, off, 48'd0, bad};
      return r;
   endfunction

   task automatic random_phase(input int n);
      longint cur_ts, true_off, noise, step, spread;
      logic [31:0] me;
      int r;
      stim_row_type row;
      cur_ts = $urandom;
      true_off = $signed($urandom_range(0, 2000000)) - 1000000;
      send_word(mk(MODE_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, $urandom));
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 68) begin
            step = ($urandom_range(0, 19) == 0) ? longint'($urandom) + 1
                                                : $urandom_range(1, 50000);
            cur_ts += step;
            true_off += $signed($urandom_range(0, 200)) - 100;
            me = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1000);
            spread = longint'(me % 1001);
            noise = longint'($urandom_range(0, 2 * (me % 1001))) - spread;
            if ($urandom_range(0, 15) == 0) noise += $urandom_range(1000, 100000);
            row = mk(MODE_UPDATE, cur_ts, true_off + noise, me);
         end else if (r < 84) begin
            row = mk($urandom_range(0, 1) ? MODE_TO_REMOTE : MODE_TO_LOCAL,
                     cur_ts + $signed($urandom_range(0, 2000000)) - 1000000,
                     {$urandom, $urandom}, $urandom);
         end else if (r < 94) begin
            row = mk($urandom_range(0, 1) ? MODE_TO_REMOTE : MODE_TO_LOCAL,
                     {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
         end else if (r < 97) begin
            row = mk(MODE_UPDATE, cur_ts - $urandom_range(0, 5000),
                     true_off, $urandom_range(0, 1000));
         end else if (r < 99) begin
            row = mk(MODE_UPDATE, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
         end else begin
            row = mk(MODE_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
         end
         send_word(row);
      end
      drain();
   endtask

   initial begin
      stim_row_type directed[$];
      cfg_pv = 64'd65536;
      cfg_ff = 64'd268435456;
      clear_filter();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(mk_typed(MODE_TO_REMOTE, 12345, 0, 0, 12345, 0, 0));
      directed.push_back(mk_typed(MODE_TO_LOCAL, -777, 0, 0, -777, 0, 0));
      directed.push_back(mk(MODE_TO_REMOTE, S_MAX, S_MIN, 32'hFFFF_FFFF));
      directed.push_back(mk(MODE_TO_LOCAL, S_MIN, S_MAX, 0));
      directed.push_back(mk_typed(MODE_UPDATE, 1000, 500, 10, 0, 500, 0));
      directed.push_back(mk_typed(MODE_UPDATE, 1000, 0, 0, 0, 500, 1));
      directed.push_back(mk_typed(MODE_UPDATE, 900, 7, 7, 0, 500, 1));
      directed.push_back(mk(MODE_UPDATE, 2000, 600, 10));
      directed.push_back(mk(MODE_UPDATE, 3000, 700, 0));
      directed.push_back(mk(MODE_UPDATE, 4000, S_MAX, 32'hFFFF_FFFF));
      directed.push_back(mk(MODE_UPDATE, 5000, S_MIN, 1));
      directed.push_back(mk(MODE_TO_REMOTE, S_MIN, 0, 0));
      directed.push_back(mk(MODE_TO_LOCAL, S_MAX, 0, 0));
      directed.push_back(mk(MODE_UPDATE, S_MAX, 100, 50));
      directed.push_back(mk(MODE_UPDATE, S_MIN, 100, 50));
      directed.push_back(mk_typed(MODE_CLEAR, 1, 2, 3, 0, 0, 0));
      directed.push_back(mk(MODE_UPDATE, 0, 0, 0));
      directed.push_back(mk(MODE_UPDATE, 1, -1, 0));
      directed.push_back(mk(MODE_TO_LOCAL, 1, 0, 0));
      directed.push_back(mk(MODE_TO_LOCAL, 0, 0, 0));
      directed.push_back(mk(MODE_TO_REMOTE, 5, 0, 0));
      directed.push_back(mk_typed(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(MODE_UPDATE, 10, 5, 32'hFFFF_FFFF));
      directed.push_back(mk(MODE_UPDATE, 20, 5, 3));
      directed.push_back(mk(MODE_UPDATE, 30, 6, 3));
      foreach (directed[i]) send_word(directed[i]);
      drain();

      write_csr(CSR_PROCESS_VARIANCE, 32'd0);
      write_csr(CSR_FORGET_FACTOR, 32'd0);
      random_phase(PHASE_ITEMS);
      write_csr(CSR_PROCESS_VARIANCE, 32'hFFFF_FFFF);
      write_csr(CSR_FORGET_FACTOR, 32'hFFFF_FFFF);
      random_phase(PHASE_ITEMS);
      write_csr(CSR_PROCESS_VARIANCE, $urandom);
      write_csr(CSR_FORGET_FACTOR, $urandom);
      random_phase(PHASE_ITEMS);
      write_csr(CSR_PROCESS_VARIANCE, 32'd65536);
      write_csr(CSR_FORGET_FACTOR, 32'h3000_0000);
      random_phase(PHASE_ITEMS);

      if (!failed) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      int n;
      bit held;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (!held && words_sent >= 250) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (4000) @(posedge clock);
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: time_out %h offset_now %h", rsp_time_out, rsp_offset_now);
            failed = 1'b1;
         end else begin
            w = expected_words.pop_front();
            if (rsp_time_out !== w.time_out) begin
               $error("time_out expected %h actual %h", w.time_out, rsp_time_out);
               failed = 1'b1;
            end
            if (rsp_offset_now !== w.offset_now) begin
               $error("offset_now expected %h actual %h", w.offset_now, rsp_offset_now);
               failed = 1'b1;
            end
            if (rsp_drift_now !== w.drift_now) begin
               $error("drift_now expected %h actual %h", w.drift_now, rsp_drift_now);
               failed = 1'b1;
            end
            if (rsp_bad_interval !== w.bad) begin
               $error("bad_interval expected %b actual %b", w.bad, rsp_bad_interval);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $error("timeout with %0d words outstanding", expected_words.size());
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule
